// ----- rtl/bswr_pkg.sv -----
// shared constants, command and status codes, and memory write type for the byte stack
`default_nettype none
package bswr_pkg;

	// storage geometry
	localparam int DEPTH       = 32;
	localparam int MAX_RESULTS = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);

	// field widths
	localparam int VAL_W = 8;
	localparam int CMD_W = 3;
	localparam int ROT_W = 6;
	localparam int CAP_W = 6;
	localparam int ST_W  = 2;

	// width wide enough to compare fill, capacity and rotate depth
	localparam int CMP_W = (CNT_W > ROT_W) ? CNT_W : ROT_W;

	// hard limit on the capacity in effect
	localparam int CAP_LIM = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DUP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROTUP = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ROTDN = 3'd5;
	localparam logic [CMD_W-1:0] CMD_PRINT = 3'd6;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_DEEP  = 2'd3;

	// one write into the entry memory
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  data;
	} mem_wr_t;

endpackage
`default_nettype wire

// ----- rtl/byte_stack_with_rotate.sv -----
// top level of the byte stack: command sequencer, fill count, capacity register, result register
// A LIFO of bytes kept in a single-port-write, registered-read memory. Each command gives one
// result, print gives one per entry from top to bottom with last on the bottom one. Push, pop,
// peek, error cases and the unknown code pass through S_EMIT or S_EMIT_RD; dup adds S_DUPW;
// a rotate of depth r (2 or more) passes S_LOAD, S_MOVE and S_LAST, with the shared index
// stepper moving one entry per cycle through the memory. Print streams one entry per cycle
// while the output is free, after a registered read. A new command is taken once the previous
// one has its last result in the output register, and capacity writes are taken every cycle.
`default_nettype none
module byte_stack_with_rotate (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bswr_pkg::CAP_W-1:0]        capacity,
	// command channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [bswr_pkg::CMD_W-1:0]        command,
	input  wire logic [bswr_pkg::VAL_W-1:0]        push_value,
	input  wire logic [bswr_pkg::ROT_W-1:0]        rotate_depth,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [bswr_pkg::VAL_W-1:0]        value,
	output logic                                   value_valid,
	output logic      [bswr_pkg::ST_W-1:0]         status,
	output logic                                   last
);

	localparam int AW  = bswr_pkg::ADDR_W;
	localparam int CW  = bswr_pkg::CNT_W;
	localparam int MW  = bswr_pkg::CMP_W;
	localparam int VW  = bswr_pkg::VAL_W;
	localparam int SW  = bswr_pkg::ST_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EMIT,
		S_EMIT_RD,
		S_DUPW,
		S_LOAD,
		S_MOVE,
		S_LAST,
		S_PRINT
	} state_t;

	state_t state_q, state_d;

	logic [bswr_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0] fill_q, fill_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [AW-1:0] end_q, end_d;
	logic          dn_q, dn_d;
	logic [VW-1:0] moved_q, moved_d;

	logic [VW-1:0] res_val_q, res_val_d;
	logic          res_vld_q, res_vld_d;
	logic [SW-1:0] res_st_q, res_st_d;

	logic          out_valid_q, out_valid_d;
	logic [VW-1:0] out_val_q, out_val_d;
	logic          out_vld_q, out_vld_d;
	logic [SW-1:0] out_st_q, out_st_d;
	logic          out_last_q, out_last_d;

	logic          out_free;
	logic [MW-1:0] fill_x, cap_x, rot_x, cap_eff;
	logic [AW-1:0] top_addr, low_addr, raddr;
	logic [VW-1:0] rdata;
	bswr_pkg::mem_wr_t wr;

	// shared index stepper: one entry toward the end of the rotate span
	function automatic logic [AW-1:0] step(input logic [AW-1:0] a, input logic down);
		return down ? a + AW'(1) : a - AW'(1);
	endfunction

	// capacity in effect and operand alignment
	always_comb begin
		fill_x   = MW'(fill_q);
		cap_x    = MW'(cap_q);
		rot_x    = MW'(rotate_depth);
		cap_eff  = (cap_x > MW'(bswr_pkg::CAP_LIM)) ? MW'(bswr_pkg::CAP_LIM) : cap_x;
		top_addr = AW'(fill_x - MW'(1));
		low_addr = AW'(fill_x - rot_x);
	end

	assign out_free = !out_valid_q || out_ready;

	// sequencer next state
	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		idx_d       = idx_q;
		end_d       = end_q;
		dn_d        = dn_q;
		moved_d     = moved_q;
		res_val_d   = res_val_q;
		res_vld_d   = res_vld_q;
		res_st_d    = res_st_q;
		out_valid_d = out_valid_q;
		out_val_d   = out_val_q;
		out_vld_d   = out_vld_q;
		out_st_d    = out_st_q;
		out_last_d  = out_last_q;
		wr          = '0;

		// result taken downstream
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_val_d = '0;
					res_vld_d = 1'b0;
					res_st_d  = bswr_pkg::ST_OK;
					state_d   = S_EMIT;
					unique case (command)
						bswr_pkg::CMD_PUSH: begin
							if (fill_x >= cap_eff) begin
								res_st_d = bswr_pkg::ST_FULL;
							end else begin
								wr.en   = 1'b1;
								wr.addr = AW'(fill_q);
								wr.data = push_value;
								fill_d  = fill_q + CW'(1);
							end
						end
						bswr_pkg::CMD_POP, bswr_pkg::CMD_PEEK: begin
							if (fill_q == '0) begin
								res_st_d = bswr_pkg::ST_EMPTY;
							end else begin
								idx_d   = top_addr;
								state_d = S_EMIT_RD;
								if (command == bswr_pkg::CMD_POP) begin
									fill_d = fill_q - CW'(1);
								end
							end
						end
						bswr_pkg::CMD_DUP: begin
							if (fill_x >= cap_eff) begin
								res_st_d = bswr_pkg::ST_FULL;
							end else if (fill_q == '0) begin
								res_st_d = bswr_pkg::ST_EMPTY;
							end else begin
								idx_d   = top_addr;
								state_d = S_DUPW;
							end
						end
						bswr_pkg::CMD_ROTUP, bswr_pkg::CMD_ROTDN: begin
							if (rot_x > fill_x) begin
								res_st_d = bswr_pkg::ST_DEEP;
							end else if (rot_x > MW'(1)) begin
								dn_d    = (command == bswr_pkg::CMD_ROTDN);
								idx_d   = (command == bswr_pkg::CMD_ROTDN) ? low_addr : top_addr;
								end_d   = (command == bswr_pkg::CMD_ROTDN) ? top_addr : low_addr;
								state_d = S_LOAD;
							end
						end
						bswr_pkg::CMD_PRINT: begin
							if (fill_q != '0) begin
								idx_d   = top_addr;
								state_d = S_PRINT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			// hand a prepared result to the output register
			S_EMIT: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_val_d   = res_val_q;
					out_vld_d   = res_vld_q;
					out_st_d    = res_st_q;
					out_last_d  = 1'b1;
					state_d     = S_IDLE;
				end
			end
			// pop or peek: top entry straight from the read port
			S_EMIT_RD: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_val_d   = rdata;
					out_vld_d   = 1'b1;
					out_st_d    = bswr_pkg::ST_OK;
					out_last_d  = 1'b1;
					state_d     = S_IDLE;
				end
			end
			// dup: copy the top entry one slot up
			S_DUPW: begin
				wr.en     = 1'b1;
				wr.addr   = AW'(fill_q);
				wr.data   = rdata;
				fill_d    = fill_q + CW'(1);
				res_val_d = '0;
				res_vld_d = 1'b0;
				res_st_d  = bswr_pkg::ST_OK;
				state_d   = S_EMIT;
			end
			// rotate: capture the entry that moves across the span
			S_LOAD: begin
				moved_d = rdata;
				state_d = S_MOVE;
			end
			// rotate: shift one entry per cycle toward the start
			S_MOVE: begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = rdata;
				if (step(idx_q, dn_q) == end_q) begin
					state_d = S_LAST;
				end else begin
					idx_d = step(idx_q, dn_q);
				end
			end
			// rotate: drop the moved entry at the far end
			S_LAST: begin
				wr.en     = 1'b1;
				wr.addr   = end_q;
				wr.data   = moved_q;
				res_val_d = moved_q;
				res_vld_d = 1'b1;
				res_st_d  = bswr_pkg::ST_OK;
				state_d   = S_EMIT;
			end
			// print: stream entries from top down to the bottom
			S_PRINT: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_val_d   = rdata;
					out_vld_d   = 1'b1;
					out_st_d    = bswr_pkg::ST_OK;
					out_last_d  = (idx_q == '0);
					if (idx_q == '0) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q - AW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// read address: one step ahead while rotating, else the current index
	assign raddr = (state_q == S_LOAD || state_q == S_MOVE) ? step(idx_d, dn_q) : idx_d;

	bswr_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	// state, fill, capacity and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cap_q       <= bswr_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid) begin
				cap_q <= capacity;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		end_q      <= end_d;
		dn_q       <= dn_d;
		moved_q    <= moved_d;
		res_val_q  <= res_val_d;
		res_vld_q  <= res_vld_d;
		res_st_q   <= res_st_d;
		out_val_q  <= out_val_d;
		out_vld_q  <= out_vld_d;
		out_st_q   <= out_st_d;
		out_last_q <= out_last_d;
	end

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign value       = out_val_q;
	assign value_valid = out_vld_q;
	assign status      = out_st_q;
	assign last        = out_last_q;

endmodule
`default_nettype wire

// ----- rtl/bswr_ram.sv -----
// entry memory of the byte stack: one write port, one registered read port
`default_nettype none
module bswr_ram (
	input  wire logic                           clk,
	input  wire bswr_pkg::mem_wr_t              wr,
	input  wire logic [bswr_pkg::ADDR_W-1:0]    raddr,
	output logic      [bswr_pkg::VAL_W-1:0]     rdata
);

	logic [bswr_pkg::VAL_W-1:0] mem_q [bswr_pkg::DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
